// ----- src/aes_pkg.sv -----
// AES-128 CBC engine package: cipher tables, round helpers and shared types.
// Used by all modules of the engine; depends on nothing else.
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int ROUNDS = 10;
    localparam int REG_IDX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IV_HIGH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IV_LOW = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 3'd4;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef struct packed {
        block_t data;
        logic   start;
    } req_t;

    typedef struct packed {
        logic   is_decrypt;
        block_t key;
        block_t iv;
    } job_ctrl_t;

    typedef struct packed {
        block_t data;
        logic   start;
        logic   is_decrypt;
        block_t key;
        block_t iv;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [10] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] get_byte(input block_t b, input int i);
        return b[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] a2;
        logic [7:0] a4;
        logic [7:0] a8;
        a2 = xtime(a);
        a4 = xtime(a2);
        a8 = xtime(a4);
        return (m[0] ? a : 8'h00) ^ (m[1] ? a2 : 8'h00)
             ^ (m[2] ? a4 : 8'h00) ^ (m[3] ? a8 : 8'h00);
    endfunction

    function automatic block_t next_round_key(input block_t k, input int r);
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ RCON[r], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic block_t enc_round(input block_t s, input block_t k, input logic last);
        logic [7:0] t [16];
        logic [7:0] o [16];
        logic [7:0] all;
        block_t res;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) & 3))];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            for (int i = 0; i < 4; i++)
            begin
                o[4*c+i] = last ? t[4*c+i]
                         : t[4*c+i] ^ all ^ xtime(t[4*c+i] ^ t[4*c+((i+1)&3)]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            res[BLOCK_W-1-8*i -: 8] = o[i];
        end
        return res ^ k;
    endfunction

    function automatic block_t dec_round(input block_t s, input block_t k, input logic last);
        logic [7:0] t [16];
        logic [7:0] o [16];
        block_t u;
        block_t res;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*((c + i) & 3)] = INV_SBOX[get_byte(s, i + 4*c)];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            u[BLOCK_W-1-8*i -: 8] = t[i];
        end
        u = u ^ k;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                o[4*c+i] = gmul(get_byte(u, 4*c + i), 4'd14)
                         ^ gmul(get_byte(u, 4*c + ((i+1)&3)), 4'd11)
                         ^ gmul(get_byte(u, 4*c + ((i+2)&3)), 4'd13)
                         ^ gmul(get_byte(u, 4*c + ((i+3)&3)), 4'd9);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            res[BLOCK_W-1-8*i -: 8] = o[i];
        end
        return last ? u : res;
    endfunction

endpackage

// ----- src/aes128_cbc_engine.sv -----
// Top level of the AES-128 CBC engine: configuration registers, front and back ends.
// Depends on aes_pkg, aes_front and aes_back.
//
// Channel  Direction  Handshake                  Payload
// in       request    in_valid / in_ready        data_high, data_low, start_of_message
// out      result     out_valid / out_ready      result_high, result_low
// cfg      write      cfg_we                     cfg_index, cfg_data
//
// An encrypted block in the back end takes one load, ten rounds of the shared round unit,
// then a write into the output register. A decrypted block first runs the key schedule
// forward to reach the last round key before its rounds. The back end takes a new block
// only once it has finished the last one. A two-entry queue lets requests enter while the
// back end works, and a stalled result holds only the next finished block in the back end.
// Reset clears the key, IV, direction and chaining value to zero.
module aes128_cbc_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_high,
    input  logic [63:0] data_low,
    input  logic        start_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]        key_high_reg;
    logic [63:0]        key_low_reg;
    logic [63:0]        iv_high_reg;
    logic [63:0]        iv_low_reg;
    logic               direction_reg;
    aes_pkg::req_t      req;
    aes_pkg::job_ctrl_t ctrl;
    aes_pkg::job_t      job;
    logic               job_valid;
    logic               job_ready;
    logic [127:0]       out_data;

    assign req = '{data: {data_high, data_low}, start: start_of_message};
    assign ctrl = '{is_decrypt: direction_reg, key: {key_high_reg, key_low_reg},
                    iv: {iv_high_reg, iv_low_reg}};
    assign result_high = out_data[127:64];
    assign result_low = out_data[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            iv_high_reg <= '0;
            iv_low_reg <= '0;
            direction_reg <= aes_pkg::DIR_ENCRYPT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_HIGH:  key_high_reg <= cfg_data;
                aes_pkg::REG_KEY_LOW:   key_low_reg <= cfg_data;
                aes_pkg::REG_IV_HIGH:   iv_high_reg <= cfg_data;
                aes_pkg::REG_IV_LOW:    iv_low_reg <= cfg_data;
                aes_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .ctrl      (ctrl),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    aes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_high) && $stable(result_low)))
        else $error("Result changed while stalled.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && job_ready) |=> !job_ready)
        else $error("Back end took two requests in a row.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> job_valid)
        else $error("Queue full while empty.");
`endif

endmodule

// ----- src/aes_front.sv -----
// Front end of the AES-128 CBC engine: takes requests and tags each with its settings.
// Depends on aes_pkg.
module aes_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  aes_pkg::req_t      req,
    input  aes_pkg::job_ctrl_t ctrl,
    output logic               job_valid,
    input  logic               job_ready,
    output aes_pkg::job_t      job
);

    aes_pkg::job_t fifo_reg [aes_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic          pop;

    assign in_ready = (count_reg != 2'(aes_pkg::QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign job_valid = (count_reg != 2'd0);
    assign pop = job_valid && job_ready;
    assign job = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{data: req.data, start: req.start,
                is_decrypt: ctrl.is_decrypt, key: ctrl.key, iv: ctrl.iv};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/aes_back.sv -----
// Back end of the AES-128 CBC engine: chaining value and the iterative cipher core.
// Depends on aes_pkg.
module aes_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  aes_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [127:0]  out_data
);

    logic            busy_reg;
    logic            expand_reg;
    logic [3:0]      round_reg;
    logic            dec_reg;
    aes_pkg::block_t state_reg;
    aes_pkg::block_t rkey_reg;
    aes_pkg::block_t chain_reg;
    aes_pkg::block_t cin_reg;
    aes_pkg::block_t result_reg;
    logic            res_valid_reg;
    aes_pkg::block_t start_chain;
    aes_pkg::block_t fwd_key;
    logic            take;
    logic            done;
    logic            finish;
    logic            last_round;
    aes_pkg::block_t round_out;
    aes_pkg::block_t dec_key;

    assign start_chain = job.start ? job.iv : chain_reg;
    assign last_round = (round_reg == 4'(aes_pkg::ROUNDS - 1));
    assign done = busy_reg && !expand_reg && (round_reg == 4'(aes_pkg::ROUNDS));
    assign finish = done && (!res_valid_reg || out_ready);
    assign job_ready = !busy_reg;
    assign take = job_valid && job_ready;
    assign out_valid = res_valid_reg;
    assign out_data = result_reg;
    assign fwd_key = aes_pkg::next_round_key(rkey_reg, int'(round_reg));

    always_comb
    begin
        dec_key = rkey_reg ^ {32'h0, rkey_reg[127:32]};
        dec_key[127:96] = rkey_reg[127:96] ^ {aes_pkg::SBOX[dec_key[23:16]]
            ^ aes_pkg::RCON[4'(aes_pkg::ROUNDS) - round_reg - 4'd1],
            aes_pkg::SBOX[dec_key[15:8]], aes_pkg::SBOX[dec_key[7:0]],
            aes_pkg::SBOX[dec_key[31:24]]};
        round_out = dec_reg
            ? aes_pkg::dec_round(state_reg, dec_key, last_round)
            : aes_pkg::enc_round(state_reg, fwd_key, last_round);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dec_reg <= job.is_decrypt;
            cin_reg <= start_chain;
            state_reg <= job.is_decrypt ? job.data : job.data ^ start_chain ^ job.key;
            rkey_reg <= job.key;
        end
        else if (busy_reg && expand_reg)
        begin
            rkey_reg <= fwd_key;
            if (last_round)
            begin
                state_reg <= state_reg ^ fwd_key;
            end
        end
        else if (busy_reg && !done)
        begin
            state_reg <= round_out;
            rkey_reg <= dec_reg ? dec_key : fwd_key;
        end
        if (finish)
        begin
            result_reg <= dec_reg ? state_reg ^ cin_reg : state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            expand_reg <= 1'b0;
            round_reg <= 4'd0;
            chain_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                expand_reg <= job.is_decrypt;
                round_reg <= 4'd0;
                chain_reg <= job.is_decrypt ? job.data : chain_reg;
            end
            else if (busy_reg && expand_reg)
            begin
                if (last_round)
                begin
                    expand_reg <= 1'b0;
                    round_reg <= 4'd0;
                end
                else
                begin
                    round_reg <= round_reg + 4'd1;
                end
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
                if (!dec_reg)
                begin
                    chain_reg <= state_reg;
                end
            end
            else if (busy_reg && !done)
            begin
                round_reg <= round_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_valid_reg && out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the AES-128 CBC engine: directed known-answer blocks, then
// random messages under random key, IV and direction, each result checked by a predictor.
// Depends on aes_pkg and aes128_cbc_engine.
`timescale 1ns / 100ps

module testbench;
    import aes_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_DIRECTION + 3'd1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 800;

    typedef struct {
        int     phase;
        block_t data;
        bit     start;
        bit     known;
        block_t golden;
    } kat_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] data_high = '0;
    logic [63:0] data_low = '0;
    logic        start_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    block_t      model_key;
    block_t      model_iv;
    logic        model_dir;
    block_t      model_chain;
    logic [7:0]  inv_sub [256];
    block_t      pending_blocks [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    aes128_cbc_engine u_dut (.*);

    always #1 clk = ~clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] m);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (m[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic void expand_schedule(input block_t key, output block_t rk [11]);
        logic [31:0] w [44];
        logic [31:0] t;
        for (int i = 0; i < 4; i++)
            w[i] = key[127-32*i -: 32];
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
                t = {SBOX[t[23:16]] ^ RCON[i/4-1], SBOX[t[15:8]], SBOX[t[7:0]],
                     SBOX[t[31:24]]};
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    function automatic block_t cipher_block(input block_t pt, input block_t key);
        block_t rk [11];
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] all;
        block_t v;
        expand_schedule(key, rk);
        v = pt ^ rk[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = v[127-8*i -: 8];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i+4*c] = SBOX[s[i + 4*((c+i)%4)]];
            for (int c = 0; c < 4; c++)
            begin
                all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
                for (int i = 0; i < 4; i++)
                    s[4*c+i] = (r == 10) ? t[4*c+i]
                             : t[4*c+i] ^ all ^ gf_mul(t[4*c+i] ^ t[4*c+(i+1)%4], 8'd2);
            end
            for (int i = 0; i < 16; i++)
                v[127-8*i -: 8] = s[i];
            v ^= rk[r];
        end
        return v;
    endfunction

    function automatic block_t decipher_block(input block_t ct, input block_t key);
        block_t rk [11];
        logic [7:0] s [16];
        logic [7:0] t [16];
        block_t v;
        expand_schedule(key, rk);
        v = ct ^ rk[10];
        for (int r = 9; r >= 0; r--)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = v[127-8*i -: 8];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4*((c+i)%4)] = inv_sub[s[i+4*c]];
            for (int i = 0; i < 16; i++)
                v[127-8*i -: 8] = t[i];
            v ^= rk[r];
            if (r != 0)
            begin
                for (int i = 0; i < 16; i++)
                    s[i] = v[127-8*i -: 8];
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        t[4*c+i] = gf_mul(s[4*c+i], 8'd14) ^ gf_mul(s[4*c+(i+1)%4], 8'd11)
                                 ^ gf_mul(s[4*c+(i+2)%4], 8'd13)
                                 ^ gf_mul(s[4*c+(i+3)%4], 8'd9);
                for (int i = 0; i < 16; i++)
                    v[127-8*i -: 8] = t[i];
            end
        end
        return v;
    endfunction

    function automatic block_t cbc_step(input block_t data, input bit start);
        block_t res;
        if (start)
            model_chain = model_iv;
        if (model_dir == DIR_ENCRYPT)
        begin
            res = cipher_block(data ^ model_chain, model_key);
            model_chain = res;
        end
        else
        begin
            res = decipher_block(data, model_key) ^ model_chain;
            model_chain = data;
        end
        return res;
    endfunction

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic block_t random_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic wait_idle();
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_KEY_HIGH:  model_key[127:64] = value;
            REG_KEY_LOW:   model_key[63:0] = value;
            REG_IV_HIGH:   model_iv[127:64] = value;
            REG_IV_LOW:    model_iv[63:0] = value;
            REG_DIRECTION: model_dir = value[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_block(input block_t data, input bit start, input bit known,
                              input block_t golden);
        block_t predicted;
        in_valid = 1'b1;
        data_high = data[127:64];
        data_low = data[63:0];
        start_of_message = start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = cbc_step(data, start);
        if (known && predicted != golden)
        begin
            $error("known answer mismatch: expected %h, predicted %h", golden, predicted);
            fail_count++;
        end
        pending_blocks.push_back(known ? golden : predicted);
        @(negedge clk);
        repeat (gap_length())
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic setup_phase(input int phase);
        wait_idle();
        case (phase)
            1:
            begin
                write_reg(REG_KEY_HIGH, 64'h0001020304050607);
                write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
            end
            2:
            begin
                write_reg(REG_DIRECTION, '1);
                for (int i = REG_SPARE_FIRST; i < 8; i++)
                    write_reg(i[2:0], '1);
            end
            3:
                write_reg(REG_KEY_LOW, '1);
            4:
            begin
                write_reg(REG_IV_HIGH, '1);
                write_reg(REG_IV_LOW, 64'h0123456789abcdef);
            end
            5:
            begin
                write_reg(REG_DIRECTION, 64'hfffffffffffffffe);
                write_reg(REG_KEY_HIGH, '1);
                write_reg(REG_IV_LOW, '1);
            end
            default: ;
        endcase
    endtask

    kat_row_t kat_rows [] = '{
        '{0, '0, 1'b0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
        '{0, '1, 1'b1, 1'b0, '0},
        '{0, '0, 1'b0, 1'b0, '0},
        '{1, 128'h00112233445566778899aabbccddeeff, 1'b1, 1'b1,
             128'h69c4e0d86a7b0430d8cdb78070b4c55a},
        '{1, '1, 1'b0, 1'b0, '0},
        '{2, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1, 1'b1,
             128'h00112233445566778899aabbccddeeff},
        '{2, 128'h8000000000000001_ffffffff00000000, 1'b0, 1'b0, '0},
        '{3, 128'h0f0f0f0f0f0f0f0f_f0f0f0f0f0f0f0f0, 1'b0, 1'b0, '0},
        '{4, '0, 1'b0, 1'b0, '0},
        '{4, '1, 1'b1, 1'b0, '0},
        '{4, '0, 1'b0, 1'b0, '0},
        '{5, '0, 1'b1, 1'b0, '0},
        '{5, '1, 1'b0, 1'b0, '0},
        '{5, 128'h00000000ffffffff_0000000000000000, 1'b0, 1'b0, '0}
    };

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("unexpected result %h %h", result_high, result_low);
                fail_count++;
            end
            else
            begin
                if (result_high !== pending_blocks[0][127:64])
                begin
                    $error("result_high: expected %h, actual %h", pending_blocks[0][127:64],
                           result_high);
                    fail_count++;
                end
                if (result_low !== pending_blocks[0][63:0])
                begin
                    $error("result_low: expected %h, actual %h", pending_blocks[0][63:0],
                           result_low);
                    fail_count++;
                end
                void'(pending_blocks.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(99) < 25)
                stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3, 1)
                                                        : $urandom_range(40, 10);
        end
    end

    initial
    begin
        int prev_phase;
        int msg_left;
        bit start;
        for (int i = 0; i < 256; i++)
            inv_sub[SBOX[i]] = i[7:0];
        model_key = '0;
        model_iv = '0;
        model_dir = DIR_ENCRYPT;
        model_chain = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        prev_phase = 0;
        foreach (kat_rows[i])
        begin
            if (kat_rows[i].phase != prev_phase)
            begin
                in_valid = 1'b0;
                setup_phase(kat_rows[i].phase);
                prev_phase = kat_rows[i].phase;
            end
            send_block(kat_rows[i].data, kat_rows[i].start, kat_rows[i].known,
                       kat_rows[i].golden);
        end

        msg_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                in_valid = 1'b0;
                wait_idle();
                calm = ($urandom_range(3) == 0);
                case ($urandom_range(3))
                    0:
                    begin
                        write_reg(REG_KEY_HIGH, '0);
                        write_reg(REG_KEY_LOW, '0);
                    end
                    1:
                    begin
                        write_reg(REG_KEY_HIGH, '1);
                        write_reg(REG_KEY_LOW, '1);
                    end
                    default:
                    begin
                        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
                        write_reg(REG_KEY_LOW, {$urandom, $urandom});
                    end
                endcase
                write_reg(REG_IV_HIGH, {$urandom, $urandom});
                write_reg(REG_IV_LOW, {$urandom, $urandom});
                write_reg(REG_DIRECTION, {$urandom, $urandom});
                msg_left = 0;
            end
            if (msg_left == 0)
            begin
                msg_left = $urandom_range(12, 1);
                start = 1'b1;
            end
            else
                start = ($urandom_range(99) < 8);
            msg_left--;
            send_block(random_block(), start, 1'b0, '0);
        end
        in_valid = 1'b0;

        wait_idle();
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
